### src/mexp_pkg.sv
// Shared word width and word type for the modular exponentiation block.
// No dependencies.
package mexp_pkg;

    localparam int WORD_BITS = 64;
    localparam int FIELD_BITS = 64;
    localparam int CNT_BITS = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] word_t;

endpackage

### src/mexp_modmul.sv
// Bit-serial modular multiplier: double-and-add, one multiplier bit per cycle.
// Depends on mexp_pkg. Requires x < m and m != 0.
module mexp_modmul
    import mexp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t x,
    input  word_t y,
    input  word_t m,
    output logic  done,
    output word_t product
);

    logic  busy_reg;
    word_t x_reg;
    word_t y_reg;
    word_t acc_reg;
    word_t sum_acc;
    word_t sum_dbl;

    function automatic word_t add_mod(input word_t a, input word_t b, input word_t md);
        logic [WORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, md})
        begin
            s = s - {1'b0, md};
        end
        return s[WORD_BITS-1:0];
    endfunction

    always_comb
    begin
        sum_acc = add_mod(acc_reg, x_reg, m);
        sum_dbl = add_mod(x_reg, x_reg, m);
    end

    // finishes as soon as the remaining multiplier bits are all zero
    assign done    = busy_reg && (y_reg == '0);
    assign product = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            y_reg   <= y;
            acc_reg <= '0;
        end
        else if (busy_reg && (y_reg != '0))
        begin
            if (y_reg[0])
            begin
                acc_reg <= sum_acc;
            end
            x_reg <= sum_dbl;
            y_reg <= {1'b0, y_reg[WORD_BITS-1:1]};
        end
    end

endmodule

### src/modular_exponentiation_64.sv
// Computes base^exponent mod modulus by right-to-left square-and-multiply over
// a bit-serial modular multiplier. One beat in gives one beat out. The base is
// first reduced by the modulus one bit per cycle. Each exponent bit up to the
// highest set one costs a check state and a squaring, plus a multiply when the
// bit is set; each product runs over the significant multiplier bits. A zero
// modulus or a zero exponent skips the reduction and goes straight to the
// finish state. A new beat is taken while the previous result waits in the
// output register.
// Uses mexp_pkg and mexp_modmul.
module modular_exponentiation_64
    import mexp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [FIELD_BITS-1:0] base,
    input  logic [FIELD_BITS-1:0] exponent,
    input  logic [FIELD_BITS-1:0] modulus,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [FIELD_BITS-1:0] power_result,
    output logic                  zero_modulus
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_EXP_CHECK,
        ST_MUL_ACC,
        ST_MUL_SQR,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic                out_valid_reg;
    logic [FIELD_BITS-1:0] result_reg;
    logic                zero_mod_reg;

    word_t               b_reg;
    word_t               e_reg;
    word_t               m_reg;
    word_t               acc_reg;
    word_t               r_reg;
    logic                err_reg;
    logic [CNT_BITS-1:0] cnt_reg;

    word_t               in_b;
    word_t               in_e;
    word_t               in_m;
    logic [WORD_BITS:0]  red_shift;
    word_t               r_next;

    logic                mul_start;
    word_t               mul_y;
    logic                mul_done;
    word_t               mul_product;
    logic                out_free;

    assign in_b = base[WORD_BITS-1:0];
    assign in_e = exponent[WORD_BITS-1:0];
    assign in_m = modulus[WORD_BITS-1:0];

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign power_result = result_reg;
    assign zero_modulus = zero_mod_reg;
    assign out_free     = !out_valid_reg || out_ready;

    // Horner reduction of the base, MSB first; r < m keeps one subtract enough
    always_comb
    begin
        red_shift = {r_reg, b_reg[WORD_BITS-1]};
        if (red_shift >= {1'b0, m_reg})
        begin
            red_shift = red_shift - {1'b0, m_reg};
        end
        r_next = red_shift[WORD_BITS-1:0];
    end

    always_comb
    begin
        mul_start = ((state_reg == ST_EXP_CHECK) && (e_reg != '0))
                 || ((state_reg == ST_MUL_ACC) && mul_done);
        mul_y     = ((state_reg == ST_EXP_CHECK) && e_reg[0]) ? acc_reg : b_reg;
    end

    mexp_modmul u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .x       (b_reg),
        .y       (mul_y),
        .m       (m_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
            zero_mod_reg  <= 1'b0;
            b_reg         <= '0;
            e_reg         <= '0;
            m_reg         <= '0;
            acc_reg       <= '0;
            r_reg         <= '0;
            err_reg       <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        b_reg   <= in_b;
                        e_reg   <= in_e;
                        m_reg   <= in_m;
                        r_reg   <= '0;
                        cnt_reg <= '0;
                        if (in_m == '0)
                        begin
                            err_reg   <= 1'b1;
                            acc_reg   <= '0;
                            state_reg <= ST_FINISH;
                        end
                        else if (in_e == '0)
                        begin
                            err_reg   <= 1'b0;
                            acc_reg   <= word_t'(1);
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            err_reg   <= 1'b0;
                            acc_reg   <= (in_m == word_t'(1)) ? '0 : word_t'(1);
                            state_reg <= ST_REDUCE;
                        end
                    end
                end
                ST_REDUCE:
                begin
                    r_reg   <= r_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_BITS'(WORD_BITS - 1))
                    begin
                        b_reg     <= r_next;
                        state_reg <= ST_EXP_CHECK;
                    end
                    else
                    begin
                        b_reg <= {b_reg[WORD_BITS-2:0], 1'b0};
                    end
                end
                ST_EXP_CHECK:
                begin
                    if (e_reg == '0)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else if (e_reg[0])
                    begin
                        state_reg <= ST_MUL_ACC;
                    end
                    else
                    begin
                        state_reg <= ST_MUL_SQR;
                    end
                end
                ST_MUL_ACC:
                begin
                    if (mul_done)
                    begin
                        acc_reg   <= mul_product;
                        state_reg <= ST_MUL_SQR;
                    end
                end
                ST_MUL_SQR:
                begin
                    if (mul_done)
                    begin
                        b_reg     <= mul_product;
                        e_reg     <= {1'b0, e_reg[WORD_BITS-1:1]};
                        state_reg <= ST_EXP_CHECK;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        result_reg    <= FIELD_BITS'(acc_reg);
                        zero_mod_reg  <= err_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### test/modular_exponentiation_64_test.sv
// Testbench for modular_exponentiation_64: directed and random operand beats, each
// result checked against a 128-bit square-and-multiply predictor in order of issue.
// Depends on mexp_pkg and the modular_exponentiation_64 RTL.
module modular_exponentiation_64_test;
    import mexp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 3000;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int DRAIN_CYCLES = 9000;
    localparam int PHASE_BEATS = 22;
    localparam int HOLD_BEATS = 12;
    localparam word_t TOP_BIT = word_t'(1) << (WORD_BITS - 1);
    localparam word_t PRIME_64 = 64'hFFFF_FFFF_FFFF_FFC5;

    typedef struct packed {
        word_t base;
        word_t exponent;
        word_t modulus;
    } operands_t;

    typedef struct packed {
        word_t power;
        logic  zero_mod;
    } power_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    word_t base = '0;
    word_t exponent = '0;
    word_t modulus = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    word_t power_result;
    logic  zero_modulus;

    operands_t operand_q[$];
    power_t    power_q[$];

    logic in_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_token = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    int   beats_queued = 0;
    int   beats_taken = 0;
    int   results_seen = 0;
    int   zero_mod_beats = 0;
    int   zero_exp_beats = 0;
    int   mismatches = 0;

    modular_exponentiation_64 DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .base         (base),
        .exponent     (exponent),
        .modulus      (modulus),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .power_result (power_result),
        .zero_modulus (zero_modulus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic word_t mod_product(word_t a, word_t b, word_t m);
        logic [2*WORD_BITS-1:0] prod;
        prod = {{WORD_BITS{1'b0}}, a} * {{WORD_BITS{1'b0}}, b};
        return word_t'(prod % {{WORD_BITS{1'b0}}, m});
    endfunction

    function automatic power_t predict_power(operands_t op);
        power_t res;
        word_t  sq;
        word_t  acc;
        word_t  e;
        res.zero_mod = 1'b0;
        if (op.modulus == '0)
        begin
            res.power = '0;
            res.zero_mod = 1'b1;
            return res;
        end
        if (op.exponent == '0)
        begin
            res.power = word_t'(1);
            return res;
        end
        sq = op.base % op.modulus;
        acc = word_t'(1) % op.modulus;
        e = op.exponent;
        while (e != '0)
        begin
            if (e[0])
                acc = mod_product(acc, sq, op.modulus);
            sq = mod_product(sq, sq, op.modulus);
            e = e >> 1;
        end
        res.power = acc;
        return res;
    endfunction

    // random value of random significant width, 1..max_width bits
    function automatic word_t rand_word(int max_width);
        word_t v;
        int    w;
        v = {$urandom, $urandom};
        w = $urandom_range(max_width, 1);
        if (w < WORD_BITS)
            v = v & ((word_t'(1) << w) - 1);
        return v;
    endfunction

    function automatic operands_t random_operands(bit compact);
        operands_t op;
        int        pick;
        op.base = ($urandom_range(3) == 0) ? rand_word(8) : word_t'({$urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 4)
            op.modulus = '0;
        else if (pick < 8)
            op.modulus = word_t'(1);
        else if (pick < 14 && !compact)
            op.modulus = TOP_BIT | rand_word(WORD_BITS);
        else if (pick < 18 && !compact)
            op.modulus = ~word_t'($urandom_range(255));
        else
            op.modulus = rand_word(compact ? 16 : WORD_BITS);
        pick = $urandom_range(99);
        if (pick < 6)
            op.exponent = '0;
        else if (pick < 14 && !compact)
            op.exponent = {$urandom, $urandom};
        else
            op.exponent = rand_word(compact ? 6 : 12);
        return op;
    endfunction

    task automatic queue_beat(operands_t op);
        operand_q.push_back(op);
        beats_queued++;
    endtask

    task automatic wait_all_results();
        while (results_seen < beats_queued)
            @(negedge clk);
    endtask

    task automatic check_field(string field, word_t want, word_t got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", field, want, got);
        end
    endtask

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (operand_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                base <= operand_q[0].base;
                exponent <= operand_q[0].exponent;
                modulus <= operand_q[0].modulus;
                void'(operand_q.pop_front());
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_token != hold_served)
        begin
            hold_served <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predicts on each input beat, checks each output beat
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                beats_taken++;
                if (modulus == '0)
                    zero_mod_beats++;
                else if (exponent == '0)
                    zero_exp_beats++;
                power_q.push_back(predict_power(operands_t'{base, exponent, modulus}));
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (power_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: %h zero_modulus %b",
                                 power_result, zero_modulus);
                end
                else
                begin
                    check_field("power_result", power_q[0].power, power_result);
                    check_field("zero_modulus", word_t'(power_q[0].zero_mod),
                                word_t'(zero_modulus));
                    void'(power_q.pop_front());
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int send_pct[4];
        int recv_pct[4];
        send_pct = '{0, 61, 0, 30};
        recv_pct = '{0, 0, 61, 30};

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero modulus beats zero exponent; zero exponent gives 1 even mod 1
        queue_beat('{'0, '0, '0});
        queue_beat('{word_t'(5), '0, word_t'(1)});
        queue_beat('{word_t'(5), '0, word_t'(7)});
        queue_beat('{'1, word_t'(5), '0});
        queue_beat('{'1, '1, '1});
        queue_beat('{'1, '1, TOP_BIT});
        queue_beat('{'1 - word_t'(1), word_t'(2), '1});
        queue_beat('{'0, word_t'(3), word_t'(13)});
        queue_beat('{word_t'(123), word_t'(1), word_t'(1)});
        queue_beat('{word_t'(2), word_t'(64), PRIME_64});
        queue_beat('{word_t'(7), word_t'(1), word_t'(1000)});
        queue_beat('{'1, word_t'(1), word_t'(10)});
        queue_beat('{word_t'(3), TOP_BIT, TOP_BIT | word_t'(1)});
        queue_beat('{word_t'(2), word_t'(10), word_t'(1025)});
        queue_beat('{PRIME_64 - word_t'(1), PRIME_64 - word_t'(1), PRIME_64});
        queue_beat('{TOP_BIT, word_t'(3), word_t'(2)});
        wait_all_results();

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = send_pct[p];
            recv_stall_pct = recv_pct[p];
            repeat (PHASE_BEATS) queue_beat(random_operands(1'b0));
            wait_all_results();
        end

        // receiver holds off while small beats keep coming, so the input stalls
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_token = hold_token + 1;
        repeat (HOLD_BEATS) queue_beat(random_operands(1'b1));
        wait_all_results();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (power_q.size() != 0)
            mismatches++;

        $display("Covered %0d beats (%0d zero modulus, %0d zero exponent) across free-running,",
                 beats_taken, zero_mod_beats, zero_exp_beats);
        $display("sparse-input, backpressure and long hold-off phases; %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
